/* sv/cts_pkg.sv */
// shared types for the color transform stack: operation codes and the
// packed multiplier/offset transform; no dependencies
package cts_pkg;

  typedef enum logic [2:0] {
    KIND_SAVE     = 3'd0,
    KIND_RESTORE  = 3'd1,
    KIND_CONCAT   = 3'd2,
    KIND_OFFSET   = 3'd3,
    KIND_MULTIPLY = 3'd4,
    KIND_ALPHA    = 3'd5
  } kind_t;

  // channels packed abgr: r in bits 7:0, a in bits 31:24
  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] scale;
  } xform_t;

endpackage

/* sv/cts_alu.sv */
// per-channel transform arithmetic: the 8-bit channel products and the
// saturating offset adds; uses cts_pkg
module cts_alu (
  input  logic [2:0]      kind,
  input  cts_pkg::xform_t cur,
  input  logic [31:0]     scale_word,
  input  logic [31:0]     offset_word,
  input  logic [7:0]      alpha_factor,
  output cts_pkg::xform_t xf_nxt
);
  import cts_pkg::*;

  // (x * y * 258) >> 16, kept to 8 bits
  function automatic logic [7:0] mul8(input logic [7:0] x, input logic [7:0] y);
    logic [15:0] p;
    logic [24:0] q;
    p = x * y;
    q = {1'b0, p, 8'b0} + {8'b0, p, 1'b0};
    return q[23:16];
  endfunction

  function automatic logic [7:0] sat8(input logic [8:0] v);
    return v[8] ? 8'hFF : v[7:0];
  endfunction

  logic [31:0] word_prod;
  logic [31:0] off_sum;
  logic [7:0]  alpha_prod;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    assign word_prod[8*k +: 8] = mul8(cur.scale[8*k +: 8], scale_word[8*k +: 8]);
    if (k < 3) begin : g_rgb
      // rgb offsets are scaled by the old multiplier before the add
      assign off_sum[8*k +: 8] = sat8({1'b0, cur.offset[8*k +: 8]} +
                                      {1'b0, mul8(offset_word[8*k +: 8],
                                                  cur.scale[8*k +: 8])});
    end else begin : g_a
      assign off_sum[8*k +: 8] = sat8({1'b0, cur.offset[8*k +: 8]} +
                                      {1'b0, offset_word[8*k +: 8]});
    end
  end

  assign alpha_prod = mul8(cur.scale[31:24], alpha_factor);

  always_comb begin
    xf_nxt = cur;
    unique case (kind_t'(kind))
      KIND_CONCAT: begin
        xf_nxt.offset = off_sum;
        xf_nxt.scale  = word_prod;
      end
      KIND_OFFSET:   xf_nxt.offset = off_sum;
      KIND_MULTIPLY: xf_nxt.scale  = word_prod;
      KIND_ALPHA:    xf_nxt.scale  = {alpha_prod, cur.scale[23:0]};
      default: ;
    endcase
  end

endmodule

/* sv/color_transform_stack_core.sv */
// top level of the color transform stack: current transform, save stack
// memory, operation sequencing and result register; uses cts_pkg, cts_alu
//
// Each input word is one operation on the current RGBA transform and yields
// exactly one result word (transform after the operation, stack level, error).
// Save, concat, offset, multiply, alpha scale and unused codes load the result
// register directly; a restore that pops goes through S_READ, as the saved
// transform comes from a registered stack memory read. One operation is in
// flight at a time; the result register lets the next operation be accepted in
// the same cycle that the previous result is taken. The stack memory holds
// STACK_DEPTH-1 transforms, needs no clearing after reset, and a push onto a
// full stack or a pop from an empty one flags error and changes nothing.
module color_transform_stack_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_scale_word,
  input  logic [31:0] in_offset_word,
  input  logic [7:0]  in_alpha_factor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_cur_scale,
  output logic [31:0] out_cur_offset,
  output logic [3:0]  out_stack_level,
  output logic        out_error
);
  import cts_pkg::*;

  localparam int SLOTS = STACK_DEPTH - 1;
  localparam int PW    = $clog2(STACK_DEPTH);
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam xform_t XFORM_RESET = '{offset: 32'h0, scale: 32'hFFFF_FFFF};

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t          state_r;
  logic [PW-1:0]   ptr_r;
  xform_t          cur_r;
  logic            out_valid_r;
  logic [31:0]     out_scale_r;
  logic [31:0]     out_offset_r;
  logic [3:0]      out_level_r;
  logic            out_error_r;
  xform_t          rd_data_r;
  xform_t          stack_mem [SLOTS];

  xform_t          alu_xf;
  logic [PW-1:0]   ptr_dec;
  logic [PW-1:0]   ptr_nxt;
  logic [AW-1:0]   rd_addr;
  logic            err_nxt;
  logic            save_ok;
  logic            pop_go;
  logic            accept;
  logic            out_load;

  cts_alu u_alu (
    .kind         (in_kind),
    .cur          (cur_r),
    .scale_word   (in_scale_word),
    .offset_word  (in_offset_word),
    .alpha_factor (in_alpha_factor),
    .xf_nxt       (alu_xf)
  );

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign ptr_dec  = ptr_r - PW'(1);
  assign rd_addr  = ptr_dec[AW-1:0];
  // a result word is loaded by a finished restore or any other accepted word
  assign out_load = (state_r == S_READ) || (accept && !pop_go);

  always_comb begin
    ptr_nxt = ptr_r;
    err_nxt = 1'b0;
    save_ok = 1'b0;
    pop_go  = 1'b0;
    unique case (kind_t'(in_kind))
      KIND_SAVE: begin
        if (ptr_r >= PW'(SLOTS)) begin
          err_nxt = 1'b1;
        end else begin
          save_ok = 1'b1;
          ptr_nxt = ptr_r + PW'(1);
        end
      end
      KIND_RESTORE: begin
        if (ptr_r == '0) begin
          err_nxt = 1'b1;
        end else begin
          pop_go  = 1'b1;
          ptr_nxt = ptr_dec;
        end
      end
      default: ;
    endcase
  end

  // stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && save_ok) begin
      stack_mem[ptr_r[AW-1:0]] <= cur_r;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      cur_r       <= XFORM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            ptr_r <= ptr_nxt;
            if (pop_go) begin
              state_r <= S_READ;
            end else begin
              cur_r        <= alu_xf;
              out_scale_r  <= alu_xf.scale;
              out_offset_r <= alu_xf.offset;
              out_level_r  <= 4'(ptr_nxt);
              out_error_r  <= err_nxt;
            end
          end
        end
        S_READ: begin
          // popped transform is taken from the registered read data
          cur_r        <= rd_data_r;
          out_scale_r  <= rd_data_r.scale;
          out_offset_r <= rd_data_r.offset;
          out_level_r  <= 4'(ptr_r);
          out_error_r  <= 1'b0;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cur_scale   = out_scale_r;
  assign out_cur_offset  = out_offset_r;
  assign out_stack_level = out_level_r;
  assign out_error       = out_error_r;

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PW'(SLOTS))
    else $error("stack pointer beyond saved slots");

  a_read_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> $past(accept && pop_go))
    else $error("read state entered without a pop");

  a_push_moves_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    accept && save_ok |=> ptr_r == $past(ptr_r) + PW'(1))
    else $error("save did not advance the stack pointer");

  a_no_accept_on_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> in_stall)
    else $error("input taken while result word is held");

endmodule

/* test/tb.sv */
// testbench for color_transform_stack_core: a directed table of operations, then random
// push/pop-heavy operation streams, each result word checked against a table row or a predictor
// depends on cts_pkg and the core RTL only
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cts_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int SAVE_SLOTS = STACK_DEPTH - 1;
  localparam int RAND_OPS = 1080;
  localparam int DIR_OPS = 26;
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  typedef struct packed {
    logic [31:0] scale;
    logic [31:0] offset;
    logic [3:0]  level;
    logic        error;
  } xform_result_t;

  typedef struct packed {
    logic [2:0]    kind;
    logic [31:0]   scale_w;
    logic [31:0]   offset_w;
    logic [7:0]    alpha_f;
    logic          typed;
    xform_result_t want;
  } op_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = '0;
  logic [31:0] in_scale_word = '0;
  logic [31:0] in_offset_word = '0;
  logic [7:0]  in_alpha_factor = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_cur_scale;
  logic [31:0] out_cur_offset;
  logic [3:0]  out_stack_level;
  logic        out_error;

  // typed expectation that travels with the word on the input port
  logic          row_typed = 1'b0;
  xform_result_t row_want = '0;

  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_stall_pct = 0;
  int unsigned   miss_cnt = 0;
  xform_result_t pending_results[$];
  xform_result_t got_res;
  xform_result_t want_res;
  xform_result_t pred_res;

  // predictor state
  xform_t        cur_xf = '{offset: 32'h0, scale: 32'hFFFF_FFFF};
  xform_t        saved_xf [SAVE_SLOTS];
  int unsigned   saved_cnt = 0;

  op_row_t       dir_ops [DIR_OPS];
  bit            push_mode = 1'b1;
  int unsigned   mode_left = 40;

  color_transform_stack_core #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_scale_word  (in_scale_word),
    .in_offset_word (in_offset_word),
    .in_alpha_factor(in_alpha_factor),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cur_scale  (out_cur_scale),
    .out_cur_offset (out_cur_offset),
    .out_stack_level(out_stack_level),
    .out_error      (out_error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] chan_mul(logic [7:0] x, logic [7:0] y);
    logic [31:0] p;
    p = {24'd0, x} * {24'd0, y} * 32'd258;
    return p[23:16];
  endfunction

  function automatic logic [31:0] scale_product(logic [31:0] a, logic [31:0] b);
    logic [31:0] r;
    for (int c = 0; c < 4; c++) r[8*c +: 8] = chan_mul(a[8*c +: 8], b[8*c +: 8]);
    return r;
  endfunction

  function automatic logic [31:0] offset_sum(logic [31:0] of, logic [31:0] sc,
                                             logic [31:0] ow);
    logic [31:0] r;
    logic [7:0]  add;
    logic [8:0]  s;
    for (int c = 0; c < 4; c++) begin
      // rgb offsets go through the old multiplier, alpha is added as is
      add = (c == 3) ? ow[31:24] : chan_mul(ow[8*c +: 8], sc[8*c +: 8]);
      s = {1'b0, of[8*c +: 8]} + {1'b0, add};
      r[8*c +: 8] = s[8] ? 8'hFF : s[7:0];
    end
    return r;
  endfunction

  function automatic xform_result_t apply_xform_op(logic [2:0] k, logic [31:0] sw,
                                                   logic [31:0] ow, logic [7:0] af);
    logic err;
    err = 1'b0;
    case (k)
      KIND_SAVE: begin
        if (saved_cnt >= SAVE_SLOTS) begin
          err = 1'b1;
        end else begin
          saved_xf[saved_cnt] = cur_xf;
          saved_cnt++;
        end
      end
      KIND_RESTORE: begin
        if (saved_cnt == 0) begin
          err = 1'b1;
        end else begin
          saved_cnt--;
          cur_xf = saved_xf[saved_cnt];
        end
      end
      KIND_CONCAT: begin
        cur_xf.offset = offset_sum(cur_xf.offset, cur_xf.scale, ow);
        cur_xf.scale = scale_product(cur_xf.scale, sw);
      end
      KIND_OFFSET: cur_xf.offset = offset_sum(cur_xf.offset, cur_xf.scale, ow);
      KIND_MULTIPLY: cur_xf.scale = scale_product(cur_xf.scale, sw);
      KIND_ALPHA: cur_xf.scale[31:24] = chan_mul(cur_xf.scale[31:24], af);
      default: ;
    endcase
    return '{cur_xf.scale, cur_xf.offset, saved_cnt[3:0], err};
  endfunction

  // hi: per-byte draws near full scale so that repeated multiplies decay slowly;
  // otherwise small bytes so that offsets do not saturate at once; some words are 0, all ones or random
  function automatic logic [31:0] pick_word(bit hi);
    logic [31:0] w;
    case ($urandom_range(7))
      0: w = '0;
      1: w = '1;
      2, 3: w = $urandom;
      default: begin
        for (int c = 0; c < 4; c++)
          w[8*c +: 8] = hi ? 8'($urandom_range(255, 192)) : 8'($urandom_range(24));
      end
    endcase
    return w;
  endfunction

  function automatic op_row_t random_op();
    op_row_t op;
    int unsigned r;
    if (mode_left == 0) begin
      push_mode = !push_mode;
      mode_left = $urandom_range(50, 30);
    end
    mode_left--;
    r = $urandom_range(99);
    if (r < 50)      op.kind = push_mode ? KIND_SAVE : KIND_RESTORE;
    else if (r < 56) op.kind = push_mode ? KIND_RESTORE : KIND_SAVE;
    else if (r < 70) op.kind = KIND_CONCAT;
    else if (r < 80) op.kind = KIND_OFFSET;
    else if (r < 89) op.kind = KIND_MULTIPLY;
    else if (r < 97) op.kind = KIND_ALPHA;
    else             op.kind = r[0] ? KIND_SPARE7 : KIND_SPARE6;
    op.scale_w = pick_word(1'b1);
    op.offset_w = pick_word(1'b0);
    case ($urandom_range(3))
      0: op.alpha_f = 8'h00;
      1: op.alpha_f = 8'hFF;
      default: op.alpha_f = 8'($urandom_range(255));
    endcase
    op.typed = 1'b0;
    op.want = '0;
    return op;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_word(input op_row_t op);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= op.kind;
    in_scale_word <= op.scale_w;
    in_offset_word <= op.offset_w;
    in_alpha_factor <= op.alpha_f;
    row_typed <= op.typed;
    row_want <= op.want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got_res = '{out_cur_scale, out_cur_offset, out_stack_level, out_error};
        if (pending_results.size() == 0) begin
          miss_cnt++;
          if (miss_cnt <= 10)
            $display("%0t: unexpected result word scale %h offset %h level %0d error %b",
                     $realtime, got_res.scale, got_res.offset, got_res.level, got_res.error);
        end else begin
          want_res = pending_results.pop_front();
          if (got_res.scale !== want_res.scale || got_res.offset !== want_res.offset ||
              got_res.level !== want_res.level || got_res.error !== want_res.error) begin
            miss_cnt++;
            if (miss_cnt <= 10)
              $display("%0t: expected scale %h offset %h level %0d error %b, got %h %h %0d %b",
                       $realtime, want_res.scale, want_res.offset, want_res.level,
                       want_res.error, got_res.scale, got_res.offset, got_res.level,
                       got_res.error);
          end
        end
      end
      if (in_valid && !in_stall) begin
        pred_res = apply_xform_op(in_kind, in_scale_word, in_offset_word, in_alpha_factor);
        pending_results.push_back(row_typed ? row_want : pred_res);
      end
    end
  end

  initial begin
    op_row_t op;
    // pop on empty, unused codes, full-scale concat, fill the stack, push on full, predicted ops, restore
    dir_ops[0] = '{KIND_RESTORE, 32'h0, 32'h0, 8'h00, 1'b1,
                   '{32'hFFFF_FFFF, 32'h0, 4'd0, 1'b1}};
    dir_ops[1] = '{KIND_SPARE6, 32'h0, 32'h0, 8'h00, 1'b1,
                   '{32'hFFFF_FFFF, 32'h0, 4'd0, 1'b0}};
    dir_ops[2] = '{KIND_SPARE7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1,
                   '{32'hFFFF_FFFF, 32'h0, 4'd0, 1'b0}};
    dir_ops[3] = '{KIND_CONCAT, 32'hFFFF_FFFF, 32'h8080_8080, 8'h00, 1'b1,
                   '{32'hFFFF_FFFF, 32'h8080_8080, 4'd0, 1'b0}};
    for (int s = 0; s < SAVE_SLOTS; s++)
      dir_ops[4 + s] = '{KIND_SAVE, 32'h0, 32'h0, 8'h00, 1'b1,
                         '{32'hFFFF_FFFF, 32'h8080_8080, 4'(s + 1), 1'b0}};
    dir_ops[19] = '{KIND_SAVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1,
                    '{32'hFFFF_FFFF, 32'h8080_8080, 4'd15, 1'b1}};
    dir_ops[20] = '{KIND_MULTIPLY, 32'h8040_2010, 32'h0, 8'h00, 1'b0, '0};
    dir_ops[21] = '{KIND_CONCAT, 32'hC0C0_C0C0, 32'hFF7F_3F01, 8'h00, 1'b0, '0};
    dir_ops[22] = '{KIND_OFFSET, 32'h0, 32'h0102_7F40, 8'h00, 1'b0, '0};
    dir_ops[23] = '{KIND_ALPHA, 32'h0, 32'h0, 8'hFF, 1'b0, '0};
    dir_ops[24] = '{KIND_ALPHA, 32'h0, 32'h0, 8'h00, 1'b0, '0};
    dir_ops[25] = '{KIND_RESTORE, 32'h0, 32'h0, 8'h00, 1'b1,
                    '{32'hFFFF_FFFF, 32'h8080_8080, 4'd14, 1'b0}};

    tx_idle_pct = 29;
    rx_stall_pct = 66;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_OPS; i++) drive_word(dir_ops[i]);

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 29 : (p == 1) ? 66 : 0;
      rx_stall_pct = (p == 0) ? 66 : (p == 1) ? 29 : 0;
      for (int n = 0; n < RAND_OPS / 3; n++) begin
        op = random_op();
        drive_word(op);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // a restore only adds the read state, so a stray word would show up well within this wait
    repeat (10) @(posedge clk);
    if (miss_cnt == 0 && pending_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

/* files.f */
sv/cts_pkg.sv
sv/cts_alu.sv
sv/color_transform_stack_core.sv
test/tb.sv
